### sv/mpb_pkg.sv
// ---------------------------------------------------------------------------
// mpb_pkg
// types, constants and helpers shared by the masked pixel blend modules
// ---------------------------------------------------------------------------
package mpb_pkg;

    localparam int LANES = 6;   // three filtered colours, three original colours
    localparam int CHANS = 3;

    typedef struct packed {
        logic [7:0] filt_blue;
        logic [7:0] filt_green;
        logic [7:0] filt_red;
        logic [7:0] filt_alpha;
        logic [7:0] orig_blue;
        logic [7:0] orig_green;
        logic [7:0] orig_red;
        logic [7:0] orig_alpha;
        logic [7:0] mask_value;
        logic       in_mask_region;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic [7:0] out_alpha;
    } pix_out_t;

    typedef enum logic [1:0] {
        MODE_FILT,
        MODE_ORIG,
        MODE_BLEND
    } mode_t;

    // per-pixel context carried alongside the divider lanes
    typedef struct packed {
        mode_t                 mode;
        logic [7:0]            m;
        logic [7:0]            fa;
        logic [7:0]            oa;
        logic [CHANS-1:0][7:0] fc;
        logic [CHANS-1:0][7:0] oc;
    } ctx_t;

    // one restoring-division lane
    typedef struct packed {
        logic [7:0] num;
        logic [7:0] rem;
        logic [7:0] den;
        logic [7:0] quo;
        logic       sat;
        logic       zero;
    } lane_t;

    typedef struct packed {
        ctx_t                  ctx;
        lane_t [LANES-1:0]     lane;
    } div_stage_t;

    // floor(x / 255), exact for x below 65280
    function automatic logic [7:0] div255(input logic [16:0] x);
        logic [16:0] t;
        begin
            t = x + 17'd1 + {8'd0, x[16:8]};
            return t[15:8];
        end
    endfunction

endpackage

### sv/mpb_prep.sv
// ---------------------------------------------------------------------------
// mpb_prep
// mode decode and dividend set-up for the un-premultiply divider chain
// ---------------------------------------------------------------------------
module mpb_prep (
    input  logic                clk,
    input  logic                en,
    input  logic                sel,
    input  mpb_pkg::pix_in_t    pix,
    output mpb_pkg::div_stage_t q
);

    mpb_pkg::div_stage_t stage_reg;
    mpb_pkg::div_stage_t stage_next;

    logic [mpb_pkg::LANES-1:0][7:0] cval;
    logic [mpb_pkg::LANES-1:0][7:0] aval;

    always_comb
    begin
        cval[0] = pix.filt_blue;
        cval[1] = pix.filt_green;
        cval[2] = pix.filt_red;
        cval[3] = pix.orig_blue;
        cval[4] = pix.orig_green;
        cval[5] = pix.orig_red;
        for (int i = 0; i < mpb_pkg::LANES; i++)
        begin
            aval[i] = (i < mpb_pkg::CHANS) ? pix.filt_alpha : pix.orig_alpha;
        end
    end

    always_comb
    begin
        logic [15:0] n;
        stage_next = '0;
        if (!sel || !pix.in_mask_region || pix.mask_value == 8'hff)
            stage_next.ctx.mode = mpb_pkg::MODE_FILT;
        else if (pix.mask_value == 8'h00)
            stage_next.ctx.mode = mpb_pkg::MODE_ORIG;
        else
            stage_next.ctx.mode = mpb_pkg::MODE_BLEND;
        stage_next.ctx.m     = pix.mask_value;
        stage_next.ctx.fa    = pix.filt_alpha;
        stage_next.ctx.oa    = pix.orig_alpha;
        stage_next.ctx.fc[0] = pix.filt_blue;
        stage_next.ctx.fc[1] = pix.filt_green;
        stage_next.ctx.fc[2] = pix.filt_red;
        stage_next.ctx.oc[0] = pix.orig_blue;
        stage_next.ctx.oc[1] = pix.orig_green;
        stage_next.ctx.oc[2] = pix.orig_red;
        for (int i = 0; i < mpb_pkg::LANES; i++)
        begin
            // c*255 + a/2, at most 65152
            n = ({cval[i], 8'd0} - {8'd0, cval[i]}) + {9'd0, aval[i][7:1]};
            stage_next.lane[i].num  = n[7:0];
            stage_next.lane[i].rem  = n[15:8];
            stage_next.lane[i].den  = aval[i];
            stage_next.lane[i].quo  = 8'd0;
            stage_next.lane[i].sat  = (n >= {aval[i], 8'd0});
            stage_next.lane[i].zero = (aval[i] == 8'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            stage_reg <= stage_next;
    end

    assign q = stage_reg;

endmodule

### sv/mpb_div_cell.sv
// ---------------------------------------------------------------------------
// mpb_div_cell
// one quotient bit of the restoring divider, all lanes side by side
// ---------------------------------------------------------------------------
module mpb_div_cell (
    input  logic                clk,
    input  logic                en,
    input  mpb_pkg::div_stage_t d,
    output mpb_pkg::div_stage_t q
);

    mpb_pkg::div_stage_t stage_reg;
    mpb_pkg::div_stage_t stage_next;

    always_comb
    begin
        logic [8:0] t;
        logic       ge;
        stage_next     = d;
        for (int i = 0; i < mpb_pkg::LANES; i++)
        begin
            t  = {d.lane[i].rem, d.lane[i].num[7]};
            ge = (t >= {1'b0, d.lane[i].den});
            stage_next.lane[i].rem = ge ? 8'(t - {1'b0, d.lane[i].den}) : t[7:0];
            stage_next.lane[i].quo = {d.lane[i].quo[6:0], ge};
            stage_next.lane[i].num = {d.lane[i].num[6:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            stage_reg <= stage_next;
    end

    assign q = stage_reg;

endmodule

### sv/mpb_mix.sv
// ---------------------------------------------------------------------------
// mpb_mix
// straight-space blend, re-premultiply and final pass/blend selection
// ---------------------------------------------------------------------------
module mpb_mix (
    input  logic                clk,
    input  logic                en,
    input  mpb_pkg::div_stage_t d,
    output mpb_pkg::pix_out_t   q
);

    logic [mpb_pkg::CHANS-1:0][7:0] s_reg, s_next;
    logic [7:0]                     a_reg, a_next;
    mpb_pkg::ctx_t                  ctx_reg;
    mpb_pkg::pix_out_t              out_reg, out_next;

    logic [mpb_pkg::LANES-1:0][7:0] u;

    // saturated / zero-alpha fix-up of the quotients
    always_comb
    begin
        for (int i = 0; i < mpb_pkg::LANES; i++)
        begin
            if (d.lane[i].zero)
                u[i] = 8'd0;
            else if (d.lane[i].sat)
                u[i] = 8'hff;
            else
                u[i] = d.lane[i].quo;
        end
    end

    always_comb
    begin
        logic [7:0] mi;
        mi = 8'hff - d.ctx.m;
        for (int i = 0; i < mpb_pkg::CHANS; i++)
        begin
            s_next[i] = mpb_pkg::div255(({9'd0, u[i]} * {9'd0, d.ctx.m})
                                        + ({9'd0, u[i + mpb_pkg::CHANS]} * {9'd0, mi}));
        end
        a_next = mpb_pkg::div255(({9'd0, d.ctx.fa} * {9'd0, d.ctx.m})
                                 + ({9'd0, d.ctx.oa} * {9'd0, mi}));
    end

    always_comb
    begin
        logic [7:0] c [mpb_pkg::CHANS];
        for (int i = 0; i < mpb_pkg::CHANS; i++)
        begin
            c[i] = mpb_pkg::div255(({9'd0, s_reg[i]} * {9'd0, a_reg}) + 17'd127);
        end
        case (ctx_reg.mode)
            mpb_pkg::MODE_FILT:
            begin
                out_next = {ctx_reg.fc[0], ctx_reg.fc[1], ctx_reg.fc[2], ctx_reg.fa};
            end
            mpb_pkg::MODE_ORIG:
            begin
                out_next = {ctx_reg.oc[0], ctx_reg.oc[1], ctx_reg.oc[2], ctx_reg.oa};
            end
            mpb_pkg::MODE_BLEND:
            begin
                if (a_reg == 8'd0)
                    out_next = '0;
                else
                    out_next = {c[0], c[1], c[2], a_reg};
            end
            default:
            begin
                out_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg   <= s_next;
            a_reg   <= a_next;
            ctx_reg <= d.ctx;
            out_reg <= out_next;
        end
    end

    assign q = out_reg;

endmodule

### sv/masked_premultiplied_pixel_blend_top.sv
// ---------------------------------------------------------------------------
// masked_premultiplied_pixel_blend_top
// per-pixel blend of a filtered and an original premultiplied bgra pixel
// ---------------------------------------------------------------------------
// Takes one pixel request per cycle while no result is held and returns one
// result per request, in order, through eleven register stages. The pipe is
// built around the un-premultiply divider: a chain of eight identical cells,
// one quotient bit each, with a set-up stage before it and two blend stages
// after it. Sustained rate is one pixel per clock while no result is held. A
// stall on a valid output freezes the whole pipe, and the input stall follows
// it at once.
// selection_active is written through the cfg channel, which is always ready;
// write it only while no request is in flight.
module masked_premultiplied_pixel_blend_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_stall,
    input  mpb_pkg::pix_in_t   src_data,
    output logic               dst_valid,
    input  logic               dst_stall,
    output mpb_pkg::pix_out_t  dst_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);

    localparam int CELLS  = 8;           // one per quotient bit
    localparam int STAGES = CELLS + 3;   // set-up, cells, two blend stages

    logic                sel_reg;
    logic [STAGES-1:0]   vld_reg;
    logic                adv;

    // chain links: link[0] from set-up, link[k+1] from cell k
    mpb_pkg::div_stage_t link [CELLS+1];

    // whole pipe moves unless a finished result is being held
    assign adv       = !(dst_valid && dst_stall);
    assign src_stall = !adv;
    assign cfg_ready = 1'b1;
    assign dst_valid = vld_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= 1'b0;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                sel_reg <= cfg_data;
            if (adv)
                vld_reg <= {vld_reg[STAGES-2:0], src_valid};
        end
    end

    // dividend set-up and mode decode
    mpb_prep u_prep (
        .clk (clk),
        .en  (adv),
        .sel (sel_reg),
        .pix (src_data),
        .q   (link[0])
    );

    // divider chain
    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        mpb_div_cell u_cell (
            .clk (clk),
            .en  (adv),
            .d   (link[k]),
            .q   (link[k+1])
        );
    end

    // blend, re-premultiply and output register
    mpb_mix u_mix (
        .clk (clk),
        .en  (adv),
        .d   (link[CELLS]),
        .q   (dst_data)
    );

endmodule

### sv/mpb_checker.sv
// ---------------------------------------------------------------------------
// mpb_checker
// port-level checks on the pixel blend handshakes
// ---------------------------------------------------------------------------
module mpb_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_stall,
    input  logic              dst_valid,
    input  logic              dst_stall,
    input  mpb_pkg::pix_out_t dst_data
);

    // input only stalls behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> (dst_valid && dst_stall))
        else $error("input stalled without a held result");

    // free output never holds back the input
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!dst_valid || !dst_stall) |-> !src_stall)
        else $error("input stalled while output free");

    // held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && dst_stall) |=> (dst_valid && $stable(dst_data)))
        else $error("held result changed");

endmodule

bind masked_premultiplied_pixel_blend_top mpb_checker u_mpb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_stall (src_stall),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
);

### sim/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the masked premultiplied pixel blend: random and
// directed pixel requests, a bit-exact blend predictor and an in-order check
// ---------------------------------------------------------------------------

class blend_scoreboard;
    mpb_pkg::pix_out_t pending[$];
    int errors;
    int matched;
    bit sel_active;

    function new();
        errors = 0;
        matched = 0;
        sel_active = 0;
    endfunction

    // straight colour from premultiplied, saturating
    function int straight(int c, int a);
        int s;
        if (a == 0)
            return 0;
        s = (c * 255 + a / 2) / a;
        return (s > 255) ? 255 : s;
    endfunction

    function int lerp(int f, int o, int m);
        return (f * m + o * (255 - m)) / 255;
    endfunction

    function void note_request(mpb_pkg::pix_in_t px);
        mpb_pkg::pix_out_t r;
        int m;
        int a;
        m = px.mask_value;
        if (!sel_active || !px.in_mask_region || m == 255)
            r = {px.filt_blue, px.filt_green, px.filt_red, px.filt_alpha};
        else if (m == 0)
            r = {px.orig_blue, px.orig_green, px.orig_red, px.orig_alpha};
        else
        begin
            a = lerp(px.filt_alpha, px.orig_alpha, m);
            if (a == 0)
                r = '0;
            else
            begin
                r.out_blue = 8'((lerp(straight(px.filt_blue, px.filt_alpha),
                    straight(px.orig_blue, px.orig_alpha), m) * a + 127) / 255);
                r.out_green = 8'((lerp(straight(px.filt_green, px.filt_alpha),
                    straight(px.orig_green, px.orig_alpha), m) * a + 127) / 255);
                r.out_red = 8'((lerp(straight(px.filt_red, px.filt_alpha),
                    straight(px.orig_red, px.orig_alpha), m) * a + 127) / 255);
                r.out_alpha = 8'(a);
            end
        end
        pending.push_back(r);
    endfunction

    function void check_result(mpb_pkg::pix_out_t got);
        mpb_pkg::pix_out_t want;
        if (pending.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result %h", $time, got);
            return;
        end
        want = pending.pop_front();
        if (got.out_blue !== want.out_blue)
            $display("%0t: blue expected %h actual %h", $time, want.out_blue, got.out_blue);
        if (got.out_green !== want.out_green)
            $display("%0t: green expected %h actual %h", $time, want.out_green,
                got.out_green);
        if (got.out_red !== want.out_red)
            $display("%0t: red expected %h actual %h", $time, want.out_red, got.out_red);
        if (got.out_alpha !== want.out_alpha)
            $display("%0t: alpha expected %h actual %h", $time, want.out_alpha,
                got.out_alpha);
        if (got !== want)
            errors++;
        else
            matched++;
    endfunction
endclass

### sim/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// top of the pixel blend bench: clock, reset, request driver, result monitor
// ---------------------------------------------------------------------------
// the block is stateless apart from selection_active, so the run is split
// into phases with the register flipped between them while the pipe is empty
module tb;

    logic              clk;
    logic              rst_n;
    logic              src_valid;
    logic              src_stall;
    mpb_pkg::pix_in_t  src_data;
    logic              dst_valid;
    logic              dst_stall;
    mpb_pkg::pix_out_t dst_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_data;

    blend_scoreboard sb;
    bit stall_enable;
    int n_sent;

    masked_premultiplied_pixel_blend_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // mostly short gaps, the odd long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // send one pixel request and hold it until the block takes it;
    // valid stays up afterwards so back-to-back requests follow directly
    task automatic send_pixel(mpb_pkg::pix_in_t px, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g != 0)
        begin
            src_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= px;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        sb.note_request(px);
        n_sent++;
    endtask

    // drop valid, wait for the pipe to drain, then allow for the latency tail
    task automatic drain();
        src_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (15) @(posedge clk);
    endtask

    task automatic write_selection(bit v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.sel_active = v;
        cfg_valid <= 1'b0;
    endtask

    function automatic mpb_pkg::pix_in_t random_pixel();
        logic [95:0] raw;
        mpb_pkg::pix_in_t px;
        int k;
        raw = {$urandom, $urandom, $urandom};
        px = raw[$bits(mpb_pkg::pix_in_t)-1:0];
        k = $urandom_range(0, 9);
        // push most pixels into the feather zone, which is where the arithmetic lives
        if (k < 7)
        begin
            px.in_mask_region = 1'b1;
            if (px.mask_value == 0 || px.mask_value == 255)
                px.mask_value = 8'($urandom_range(1, 254));
        end
        else if (k == 7)
            px.mask_value = ($urandom_range(0, 1) != 0) ? 8'd0 : 8'd255;
        // sometimes make the colours legal premultiplied values
        if ($urandom_range(0, 1) != 0)
        begin
            px.filt_blue  = 8'(px.filt_blue  % (int'(px.filt_alpha) + 1));
            px.filt_green = 8'(px.filt_green % (int'(px.filt_alpha) + 1));
            px.filt_red   = 8'(px.filt_red   % (int'(px.filt_alpha) + 1));
            px.orig_blue  = 8'(px.orig_blue  % (int'(px.orig_alpha) + 1));
            px.orig_green = 8'(px.orig_green % (int'(px.orig_alpha) + 1));
            px.orig_red   = 8'(px.orig_red   % (int'(px.orig_alpha) + 1));
        end
        if ($urandom_range(0, 15) == 0)
            px.filt_alpha = 8'd0;
        if ($urandom_range(0, 15) == 0)
            px.orig_alpha = 8'd0;
        return px;
    endfunction

    // directed corners: pass paths, zero alphas, colour above alpha, mask extremes
    task automatic directed_pixels();
        mpb_pkg::pix_in_t px;
        px = '0;
        px.in_mask_region = 1'b1;
        px.mask_value = 8'd128;
        send_pixel(px, 0);
        px = '1;
        send_pixel(px, 0);
        px.mask_value = 8'd0;
        send_pixel(px, 0);
        px.mask_value = 8'd1;
        send_pixel(px, 0);
        px.mask_value = 8'd254;
        send_pixel(px, 0);
        px = {8'd200, 8'd10, 8'd255, 8'd20, 8'd5, 8'd90, 8'd255, 8'd100, 8'd77, 1'b1};
        send_pixel(px, 0);
        px.in_mask_region = 1'b0;
        send_pixel(px, 0);
        px.in_mask_region = 1'b1;
        px.mask_value = 8'd255;
        send_pixel(px, 0);
        px.mask_value = 8'd0;
        send_pixel(px, 0);
        // both alphas zero but colours set
        px = {8'd40, 8'd50, 8'd60, 8'd0, 8'd70, 8'd80, 8'd90, 8'd0, 8'd100, 1'b1};
        send_pixel(px, 0);
        // filtered alpha zero only, then original only
        px.orig_alpha = 8'd200;
        send_pixel(px, 0);
        px = {8'd255, 8'd128, 8'd1, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd3, 1'b1};
        send_pixel(px, 0);
        px = {8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 1'b1};
        send_pixel(px, 0);
        px = {8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 1'b0};
        send_pixel(px, 0);
    endtask

    // result side: random stall, every accepted result goes to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (dst_valid && !dst_stall)
                sb.check_result(dst_data);
            dst_stall <= stall_enable ? (gap_len() != 0) : 1'b0;
        end
    end

    initial
    begin
        #40_000_000;
        $display("masked_premultiplied_pixel_blend_top verification failed");
        $finish;
    end

    initial
    begin
        sb = new();
        n_sent = 0;
        stall_enable = 0;
        rst_n = 1'b0;
        src_valid = 1'b0;
        src_data = '0;
        dst_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // selection off after reset: everything should pass filtered
        directed_pixels();
        drain();
        write_selection(1'b1);
        directed_pixels();
        drain();
        write_selection(1'b0);
        stall_enable = 1;
        repeat (150) send_pixel(random_pixel(), 1);
        drain();
        write_selection(1'b1);
        repeat (500) send_pixel(random_pixel(), 1);
        // hold off until the pipe is empty, then resume
        drain();
        repeat (300) send_pixel(random_pixel(), 1);
        // back-to-back stretch with no idling on either side
        stall_enable = 0;
        repeat (250) send_pixel(random_pixel(), 0);
        stall_enable = 1;
        drain();
        repeat (20) @(posedge clk);

        $display("sent %0d pixel requests over both selection settings, %0d results matched",
            n_sent, sb.matched);
        $display("covered pass-through, original, feather blend and zero-alpha paths");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("masked_premultiplied_pixel_blend_top verification clean");
        else
            $display("masked_premultiplied_pixel_blend_top verification failed");
        $finish;
    end
endmodule

### files.f
sv/mpb_pkg.sv
sv/mpb_prep.sv
sv/mpb_div_cell.sv
sv/mpb_mix.sv
sv/masked_premultiplied_pixel_blend_top.sv
sv/mpb_checker.sv
sim/tb.sv
sim/tb_top.sv
